FILE: rtl/core/mcrw_pkg.sv
// types, constants and codes shared by the restart watchdog modules
`default_nettype none

package mcrw_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned HourW  = 5;
  localparam int unsigned MinW   = 6;
  localparam int unsigned CountW = 8;
  localparam int unsigned CauseW = 5;
  localparam int unsigned CfgIdxW = 3;

  localparam int unsigned InDataW  = 80;
  localparam int unsigned OutDataW = 8;

  localparam logic [TimeW-1:0]  WarnGapSec        = TimeW'(10);
  localparam logic [CountW-1:0] DailySecondNotice = CountW'(30);
  localparam logic [CountW-1:0] CountMax          = CountW'(255);

  localparam logic [TimeW-1:0] IdleLimitRst = TimeW'(20 * 60);
  localparam logic [TimeW-1:0] BusyLimitRst = TimeW'(5 * 60 * 60);
  localparam logic [TimeW-1:0] DeadLimitRst = TimeW'(5 * 60);
  localparam logic [TimeW-1:0] HungLimitRst = TimeW'(20 * 60);

  // cause mask bit positions
  localparam int unsigned CauseBusy  = 0;
  localparam int unsigned CauseIdle  = 1;
  localparam int unsigned CauseDead  = 2;
  localparam int unsigned CauseHung  = 3;
  localparam int unsigned CauseDaily = 4;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_IDLE_LIMIT   = 3'd0,
    CFG_BUSY_LIMIT   = 3'd1,
    CFG_DEAD_LIMIT   = 3'd2,
    CFG_HUNG_LIMIT   = 3'd3,
    CFG_DAILY_ENABLE = 3'd4,
    CFG_DAILY_HOUR   = 3'd5,
    CFG_DAILY_MINUTE = 3'd6,
    CFG_UNUSED       = 3'd7
  } mcrw_cfg_idx_e;

  typedef enum logic [2:0] {
    OP_CLIENT   = 3'd0,
    OP_INIT     = 3'd1,
    OP_PROGRESS = 3'd2,
    OP_BOUNDARY = 3'd3,
    OP_ROUND    = 3'd4,
    OP_OBJECT   = 3'd5,
    OP_SHUTDOWN = 3'd6,
    OP_TICK     = 3'd7
  } mcrw_op_e;

  typedef struct packed {
    logic [TimeW-1:0] idle_limit;
    logic [TimeW-1:0] busy_limit;
    logic [TimeW-1:0] dead_limit;
    logic [TimeW-1:0] hung_limit;
    logic             daily_enable;
    logic [HourW-1:0] daily_hour;
    logic [MinW-1:0]  daily_minute;
  } mcrw_cfg_t;

  typedef struct packed {
    logic [MinW-1:0]  clock_minute;
    logic [HourW-1:0] clock_hour;
    logic [TimeW-1:0] roster_time;
    logic             no_players;
    logic [TimeW-1:0] now_sec;
    mcrw_op_e         opcode;
  } mcrw_item_t;

  typedef struct packed {
    logic [TimeW-1:0]  last_restart_time;
    logic [TimeW-1:0]  idle_start_time;
    logic [TimeW-1:0]  last_progress_time;
    logic [TimeW-1:0]  last_warning_time;
    logic [CountW-1:0] daily_match_count;
  } mcrw_state_t;

  typedef struct packed {
    logic              daily_notice;
    logic              busy_warning;
    logic [CauseW-1:0] cause_mask;
    logic              restart;
  } mcrw_res_t;

  // base + limit < now, compared at 33 bits
  function automatic logic sum_before(logic [TimeW-1:0] base, logic [TimeW-1:0] limit,
                                      logic [TimeW-1:0] now);
    logic [TimeW:0] sum;
    sum = {1'b0, base} + {1'b0, limit};
    return sum < {1'b0, now};
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/mcrw_eval.sv
// next-state and result logic for one event of the restart watchdog
`default_nettype none

module mcrw_eval (
  input  mcrw_pkg::mcrw_cfg_t   cfg_i,
  input  mcrw_pkg::mcrw_state_t state_i,
  input  mcrw_pkg::mcrw_item_t  item_i,
  output mcrw_pkg::mcrw_state_t state_o,
  output mcrw_pkg::mcrw_res_t   res_o
);
  import mcrw_pkg::*;

  logic [TimeW-1:0]  now;
  logic [CauseW-1:0] cause;
  logic              warn;
  logic              notice;
  logic              busy_due;
  logic              idle_rs;
  logic              dead_rs;
  logic              hung_rs;
  logic              match;
  logic [CountW-1:0] count_inc;
  mcrw_state_t       st;

  always_comb begin
    now       = item_i.now_sec;
    st        = state_i;
    cause     = '0;
    warn      = 1'b0;
    notice    = 1'b0;
    idle_rs   = 1'b0;
    dead_rs   = 1'b0;
    hung_rs   = 1'b0;
    busy_due  = sum_before(state_i.last_restart_time, cfg_i.busy_limit, now);
    match     = cfg_i.daily_enable && (item_i.clock_hour == cfg_i.daily_hour) &&
                (item_i.clock_minute == cfg_i.daily_minute);
    count_inc = (state_i.daily_match_count < CountMax) ?
                state_i.daily_match_count + CountW'(1) : state_i.daily_match_count;

    case (item_i.opcode)
      OP_CLIENT: begin
        st.idle_start_time = '0;
      end
      OP_INIT: begin
        st.last_restart_time  = now;
        st.last_progress_time = now;
        st.idle_start_time    = '0;
      end
      OP_PROGRESS, OP_ROUND: begin
        st.idle_start_time    = '0;
        st.last_progress_time = now;
        warn = (item_i.opcode == OP_ROUND) && busy_due;
      end
      OP_BOUNDARY: begin
        st.idle_start_time    = '0;
        st.last_progress_time = now;
        if (busy_due) begin
          st.last_restart_time = now;
          cause[CauseBusy]     = 1'b1;
        end
      end
      OP_OBJECT: begin
        st.idle_start_time    = '0;
        st.last_progress_time = now;
        if (busy_due && sum_before(state_i.last_warning_time, WarnGapSec, now)) begin
          st.last_warning_time = now;
          warn = 1'b1;
        end
      end
      OP_SHUTDOWN: begin
        st.last_restart_time = now;
        st.idle_start_time   = '0;
      end
      OP_TICK: begin
        if (item_i.no_players) begin
          if (state_i.idle_start_time == '0) begin
            st.idle_start_time = now;
          end else begin
            idle_rs = sum_before(state_i.idle_start_time, cfg_i.idle_limit, now);
          end
        end else begin
          st.idle_start_time = '0;
        end
        dead_rs = (item_i.roster_time != '0) &&
                  ((now - item_i.roster_time) > cfg_i.dead_limit);
        // an earlier restart in this tick moves progress time to now
        hung_rs = !idle_rs && !dead_rs &&
                  ((now - state_i.last_progress_time) > cfg_i.hung_limit);
        if (match) begin
          st.daily_match_count = count_inc;
          notice = (count_inc == CountW'(1)) || (count_inc == DailySecondNotice);
        end else if (state_i.daily_match_count != '0) begin
          st.daily_match_count = '0;
          cause[CauseDaily]    = 1'b1;
        end
        cause[CauseIdle] = idle_rs;
        cause[CauseDead] = dead_rs;
        cause[CauseHung] = hung_rs;
        if (cause != '0) begin
          st.last_restart_time  = now;
          st.last_progress_time = now;
          st.idle_start_time    = '0;
        end
      end
      default: begin
        st = state_i;
      end
    endcase

    state_o            = st;
    res_o.restart      = (cause != '0);
    res_o.cause_mask   = cause;
    res_o.busy_warning = warn;
    res_o.daily_notice = notice;
  end

endmodule

`default_nettype wire

FILE: rtl/core/multi_condition_restart_watchdog.sv
// an accepted event goes to the input register, its result to the result register
// throughput: one event per cycle; the input register loads whenever it is empty or
// the result register is empty or its transaction completes
// reset: asynchronous active low; limits return to defaults, all times and the
// daily counter clear, both pipeline registers empty
`default_nettype none

module multi_condition_restart_watchdog (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            cfg_we_i,
  input  wire [mcrw_pkg::CfgIdxW-1:0]    cfg_addr_i,
  input  wire [mcrw_pkg::TimeW-1:0]      cfg_data_i,
  input  wire                            s_axis_tvalid,
  output logic                           s_axis_tready,
  // opcode, now_sec, no_players, roster_time, clock_hour, clock_minute, zero pad
  input  wire [mcrw_pkg::InDataW-1:0]    s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  wire                            m_axis_tready,
  // restart, cause_mask, busy_warning, daily_notice
  output logic [mcrw_pkg::OutDataW-1:0]  m_axis_tdata
);
  import mcrw_pkg::*;

  mcrw_cfg_t   cfg_q;
  mcrw_state_t state_q, state_d;
  mcrw_item_t  item_q;
  logic        in_valid_q;
  mcrw_res_t   res_d, res_q;
  logic        out_valid_q;
  logic        advance;
  logic        in_fire;

  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.idle_limit   <= IdleLimitRst;
      cfg_q.busy_limit   <= BusyLimitRst;
      cfg_q.dead_limit   <= DeadLimitRst;
      cfg_q.hung_limit   <= HungLimitRst;
      cfg_q.daily_enable <= 1'b0;
      cfg_q.daily_hour   <= '0;
      cfg_q.daily_minute <= '0;
    end else if (cfg_we_i) begin
      case (mcrw_cfg_idx_e'(cfg_addr_i))
        CFG_IDLE_LIMIT:   cfg_q.idle_limit   <= cfg_data_i;
        CFG_BUSY_LIMIT:   cfg_q.busy_limit   <= cfg_data_i;
        CFG_DEAD_LIMIT:   cfg_q.dead_limit   <= cfg_data_i;
        CFG_HUNG_LIMIT:   cfg_q.hung_limit   <= cfg_data_i;
        CFG_DAILY_ENABLE: cfg_q.daily_enable <= cfg_data_i[0];
        CFG_DAILY_HOUR:   cfg_q.daily_hour   <= cfg_data_i[HourW-1:0];
        CFG_DAILY_MINUTE: cfg_q.daily_minute <= cfg_data_i[MinW-1:0];
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q <= mcrw_item_t'(s_axis_tdata[$bits(mcrw_item_t)-1:0]);
    end
  end

  mcrw_eval u_eval (
    .cfg_i   (cfg_q),
    .state_i (state_q),
    .item_i  (item_q),
    .state_o (state_d),
    .res_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
      if (in_valid_q) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = res_q;

`ifndef ASSERT_OFF
  a_restart_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (res_q.restart == (res_q.cause_mask != '0)))
    else $error("restart flag disagrees with cause mask");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> s_axis_tready)
    else $error("input stalled with empty result register");

  a_idle_only_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q.idle_start_time != $past(state_q.idle_start_time)) &&
     (state_q.idle_start_time != '0)) |->
    $past(advance && in_valid_q && (item_q.opcode == OP_TICK)))
    else $error("idle start time set outside a tick");

  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(advance && in_valid_q) |-> (state_q == $past(state_q)))
    else $error("watchdog state changed without an event");
`endif

endmodule

`default_nettype wire
